// ----- rtl/core/srdw_pkg.sv -----
// srdw_pkg: word types, result codes and field widths for the sensor report
// duplicate filter and window table
// no dependencies
package srdw_pkg;

   // action codes
   localparam logic ACTION_REPORT = 1'b0;
   localparam logic ACTION_FLUSH  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_VERDICT = 2'd0;
   localparam logic [1:0] KIND_RECORD  = 2'd1;
   localparam logic [1:0] KIND_EOW     = 2'd2;

   // verdict codes
   localparam logic [1:0] VERDICT_ACCEPTED = 2'd0;
   localparam logic [1:0] VERDICT_REJECTED = 2'd1;
   localparam logic [1:0] VERDICT_FULL     = 2'd2;
   localparam logic [1:0] VERDICT_NONE     = 2'd3;

   localparam logic [31:0] STALE_TIMEOUT_RESET = 32'd30000;

   // input word
   typedef struct packed {
      logic               action;
      logic [7:0]         origin_node;
      logic [7:0]         report_seq;
      logic [31:0]        time_ms;
      logic signed [15:0] temperature;
      logic [15:0]        humidity;
      logic [15:0]        co2_level;
      logic [15:0]        voc_level;
      logic               link_ready;
   } req_type;

   // result word
   typedef struct packed {
      logic [1:0]         kind;
      logic [1:0]         verdict;
      logic [7:0]         rec_node;
      logic [31:0]        rec_time;
      logic signed [15:0] rec_temperature;
      logic [15:0]        rec_humidity;
      logic [15:0]        rec_co2;
      logic [15:0]        rec_voc;
      logic               last;
   } rsp_type;

   // sequence table entry
   typedef struct packed {
      logic [7:0]  key;
      logic [7:0]  seq_num;
      logic [31:0] seen_time;
   } seq_entry_type;

   // window table row
   typedef struct packed {
      logic [7:0]         node;
      logic [31:0]        time_ms;
      logic signed [15:0] temperature;
      logic [15:0]        humidity;
      logic [15:0]        co2;
      logic [15:0]        voc;
   } win_row_type;

endpackage

// ----- rtl/core/sensor_report_dedup_and_window_table.sv -----
// sensor_report_dedup_and_window_table: top level, sequence table and window table
// depends on srdw_pkg
//
// A report word is looked up in a sequence table of MAX_NODES entries held in a
// synchronous memory, scanned one entry per cycle; a new node takes the lowest
// free entry. The report passes when the wrapped time since the node was last
// seen exceeds the stale timeout or its sequence is strictly greater than the
// stored one; a passing report then updates the node's row in the window memory,
// found by a second one-row-per-cycle scan over the rows in use. Every report
// gives one verdict word. A flush word with the link ready sends every row, one
// window memory read per row, and then an end marker; the window table is
// emptied either way. The input stalls while a word is in progress; the result
// sits in an output register and is held while rsp_stall is high.
module sensor_report_dedup_and_window_table
   import srdw_pkg::*;
#(
   parameter int MAX_NODES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_word,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);
   localparam logic [IW-1:0] LAST_IDX  = IW'(MAX_NODES - 1);
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_NODES);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SEQ_SCAN = 3'd1;
   localparam logic [2:0] ST_CHECK    = 3'd2;
   localparam logic [2:0] ST_WIN_SCAN = 3'd3;
   localparam logic [2:0] ST_RESP     = 3'd4;
   localparam logic [2:0] ST_FL_RD    = 3'd5;
   localparam logic [2:0] ST_FL_OUT   = 3'd6;
   localparam logic [2:0] ST_EOW      = 3'd7;

   logic [2:0]           state_ff, state_in;
   req_type              item_ff, item_in;
   logic [IW-1:0]        scan_ff, scan_in;
   logic                 cmp_pend_ff, cmp_pend_in;
   logic [IW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                 free_found_ff, free_found_in;
   logic [IW-1:0]        free_idx_ff, free_idx_in;
   logic [IW-1:0]        hit_idx_ff, hit_idx_in;
   logic                 alloc_ff, alloc_in;
   logic [7:0]           ent_last_ff, ent_last_in;
   logic [31:0]          ent_time_ff, ent_time_in;
   logic [1:0]           verdict_ff, verdict_in;
   logic [MAX_NODES-1:0] valid_ff, valid_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [31:0]          timeout_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   // memories and their ports
   seq_entry_type        seq_mem [MAX_NODES];
   seq_entry_type        seq_rd_ff;
   logic                 seq_ren;
   logic [IW-1:0]        seq_raddr;
   logic                 seq_we;
   logic [IW-1:0]        seq_waddr;
   seq_entry_type        seq_wdata;

   win_row_type          win_mem [MAX_NODES];
   win_row_type          win_rd_ff;
   logic                 win_ren;
   logic [IW-1:0]        win_raddr;
   logic                 win_we;
   logic [IW-1:0]        win_waddr;
   win_row_type          win_wdata;

   logic                 rsp_free;
   logic                 rsp_load;
   rsp_type              rsp_load_word;
   logic [31:0]          elapsed;
   logic                 pass;
   win_row_type          new_row;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // sequence check on the entry found or allocated
   assign elapsed = item_ff.time_ms - ent_time_ff;
   assign pass    = (elapsed > timeout_ff) || (item_ff.report_seq > ent_last_ff);

   // row written by a passing report
   assign new_row = '{node: item_ff.origin_node, time_ms: item_ff.time_ms,
                      temperature: item_ff.temperature, humidity: item_ff.humidity,
                      co2: item_ff.co2_level, voc: item_ff.voc_level};

   // sequencer
   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      scan_in       = scan_ff;
      cmp_pend_in   = cmp_pend_ff;
      cmp_idx_in    = cmp_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_idx_in    = hit_idx_ff;
      alloc_in      = alloc_ff;
      ent_last_in   = ent_last_ff;
      ent_time_in   = ent_time_ff;
      verdict_in    = verdict_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      rsp_load      = 1'b0;
      rsp_load_word = '0;
      seq_ren       = 1'b0;
      seq_raddr     = scan_ff;
      seq_we        = 1'b0;
      seq_waddr     = hit_idx_ff;
      seq_wdata     = '0;
      win_ren       = 1'b0;
      win_raddr     = scan_ff;
      win_we        = 1'b0;
      win_waddr     = cmp_idx_ff;
      win_wdata     = new_row;

      case (state_ff)
         ST_IDLE: begin
            scan_in       = '0;
            cmp_pend_in   = 1'b0;
            free_found_in = 1'b0;
            alloc_in      = 1'b0;
            if (req_valid) begin
               item_in = req_word;
               if (req_word.action == ACTION_FLUSH) begin
                  if (!req_word.link_ready) begin
                     count_in = '0;
                  end else if (count_ff == '0) begin
                     state_in = ST_EOW;
                  end else begin
                     state_in = ST_FL_RD;
                  end
               end else begin
                  state_in = ST_SEQ_SCAN;
               end
            end
         end

         // one read issued and one compare done per cycle
         ST_SEQ_SCAN: begin
            seq_ren     = 1'b1;
            cmp_pend_in = 1'b1;
            cmp_idx_in  = scan_ff;
            if (scan_ff != LAST_IDX) begin
               scan_in = scan_ff + 1'b1;
            end
            if (cmp_pend_ff) begin
               if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = cmp_idx_ff;
               end
               if (valid_ff[cmp_idx_ff] && seq_rd_ff.key == item_ff.origin_node) begin
                  hit_idx_in  = cmp_idx_ff;
                  ent_last_in = seq_rd_ff.seq_num;
                  ent_time_in = seq_rd_ff.seen_time;
                  state_in    = ST_CHECK;
               end else if (cmp_idx_ff == LAST_IDX) begin
                  // not in the table: take the lowest free entry
                  if (free_found_ff || !valid_ff[cmp_idx_ff]) begin
                     hit_idx_in  = free_found_ff ? free_idx_ff : cmp_idx_ff;
                     alloc_in    = 1'b1;
                     ent_last_in = '0;
                     ent_time_in = '0;
                     state_in    = ST_CHECK;
                  end else begin
                     verdict_in = VERDICT_FULL;
                     state_in   = ST_RESP;
                  end
               end
            end
         end

         // write back the entry on a pass or a new node, start the window scan on a pass
         ST_CHECK: begin
            scan_in     = '0;
            cmp_pend_in = 1'b0;
            if (alloc_ff) begin
               valid_in[hit_idx_ff] = 1'b1;
            end
            if (pass) begin
               seq_we     = 1'b1;
               seq_wdata  = '{key: item_ff.origin_node, seq_num: item_ff.report_seq,
                              seen_time: item_ff.time_ms};
               verdict_in = VERDICT_ACCEPTED;
               state_in   = ST_WIN_SCAN;
            end else begin
               seq_we     = alloc_ff;
               seq_wdata  = '{key: item_ff.origin_node, seq_num: 8'd0, seen_time: 32'd0};
               verdict_in = VERDICT_REJECTED;
               state_in   = ST_RESP;
            end
         end

         // find the node's row among those in use, else append
         ST_WIN_SCAN: begin
            if (count_ff == '0) begin
               win_we    = 1'b1;
               win_waddr = '0;
               count_in  = count_ff + 1'b1;
               state_in  = ST_RESP;
            end else begin
               win_ren     = 1'b1;
               cmp_pend_in = 1'b1;
               cmp_idx_in  = scan_ff;
               if (scan_ff != LAST_IDX) begin
                  scan_in = scan_ff + 1'b1;
               end
               if (cmp_pend_ff) begin
                  if (win_rd_ff.node == item_ff.origin_node) begin
                     win_we    = 1'b1;
                     win_waddr = cmp_idx_ff;
                     state_in  = ST_RESP;
                  end else if (CW'(cmp_idx_ff) == count_ff - 1'b1) begin
                     if (count_ff < COUNT_MAX) begin
                        win_we    = 1'b1;
                        win_waddr = count_ff[IW-1:0];
                        count_in  = count_ff + 1'b1;
                     end
                     state_in = ST_RESP;
                  end
               end
            end
         end

         // verdict word
         ST_RESP: begin
            if (rsp_free) begin
               rsp_load              = 1'b1;
               rsp_load_word.kind    = KIND_VERDICT;
               rsp_load_word.verdict = verdict_ff;
               rsp_load_word.last    = 1'b1;
               state_in              = ST_IDLE;
            end
         end

         // flush: read a row, then send it
         ST_FL_RD: begin
            win_ren   = 1'b1;
            win_raddr = scan_ff;
            state_in  = ST_FL_OUT;
         end

         ST_FL_OUT: begin
            if (rsp_free) begin
               rsp_load                      = 1'b1;
               rsp_load_word.kind            = KIND_RECORD;
               rsp_load_word.verdict         = VERDICT_NONE;
               rsp_load_word.rec_node        = win_rd_ff.node;
               rsp_load_word.rec_time        = win_rd_ff.time_ms;
               rsp_load_word.rec_temperature = win_rd_ff.temperature;
               rsp_load_word.rec_humidity    = win_rd_ff.humidity;
               rsp_load_word.rec_co2         = win_rd_ff.co2;
               rsp_load_word.rec_voc         = win_rd_ff.voc;
               rsp_load_word.last            = 1'b0;
               if (CW'(scan_ff) == count_ff - 1'b1) begin
                  state_in = ST_EOW;
               end else begin
                  scan_in  = scan_ff + 1'b1;
                  state_in = ST_FL_RD;
               end
            end
         end

         // end of window marker, table emptied
         ST_EOW: begin
            if (rsp_free) begin
               rsp_load              = 1'b1;
               rsp_load_word.kind    = KIND_EOW;
               rsp_load_word.verdict = VERDICT_NONE;
               rsp_load_word.last    = 1'b1;
               count_in              = '0;
               state_in              = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_in       = rsp_load_word;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         count_ff     <= '0;
         timeout_ff   <= STALE_TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
         cmp_pend_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cmp_pend_ff  <= cmp_pend_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      scan_ff       <= scan_in;
      cmp_idx_ff    <= cmp_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_idx_ff    <= hit_idx_in;
      alloc_ff      <= alloc_in;
      ent_last_ff   <= ent_last_in;
      ent_time_ff   <= ent_time_in;
      verdict_ff    <= verdict_in;
      rsp_ff        <= rsp_in;
   end

   // sequence table memory
   always_ff @(posedge clock) begin
      if (seq_we) begin
         seq_mem[seq_waddr] <= seq_wdata;
      end
      if (seq_ren) begin
         seq_rd_ff <= seq_mem[seq_raddr];
      end
   end

   // window table memory
   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[win_waddr] <= win_wdata;
      end
      if (win_ren) begin
         win_rd_ff <= win_mem[win_raddr];
      end
   end

endmodule

// ----- sim/dedup_window_checker.sv -----
// dedup_window_checker: watches the request, result and csr ports of the sensor
// report filter, predicts every result word and compares it with what arrives
// depends on srdw_pkg
module dedup_window_checker
   import srdw_pkg::*;
#(
   parameter int MAX_NODES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_word,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_word,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // shadow copy of the sequence table, window table and timeout
   logic [7:0]  node_key  [MAX_NODES];
   logic [7:0]  node_seq  [MAX_NODES];
   logic [31:0] node_seen [MAX_NODES];
   logic        node_used [MAX_NODES];
   win_row_type win_rows  [MAX_NODES];
   int          win_count;
   logic [31:0] stale_limit;

   // result words still owed by the block, oldest first
   rsp_type     due_words[$];
   int          words_seen;

   // work out the result words of one accepted request word
   task automatic predict_dedup(input req_type w);
      int      i;
      int      slot;
      int      row;
      rsp_type r;
      slot = -1;
      row  = -1;
      // flush: dump rows if the link is up, then empty the window either way
      if (w.action == ACTION_FLUSH) begin
         if (w.link_ready) begin
            for (i = 0; i < win_count; i++) begin
               r                 = '0;
               r.kind            = KIND_RECORD;
               r.verdict         = VERDICT_NONE;
               r.rec_node        = win_rows[i].node;
               r.rec_time        = win_rows[i].time_ms;
               r.rec_temperature = win_rows[i].temperature;
               r.rec_humidity    = win_rows[i].humidity;
               r.rec_co2         = win_rows[i].co2;
               r.rec_voc         = win_rows[i].voc;
               due_words.push_back(r);
            end
            r         = '0;
            r.kind    = KIND_EOW;
            r.verdict = VERDICT_NONE;
            r.last    = 1'b1;
            due_words.push_back(r);
         end
         win_count = 0;
         return;
      end
      // lookup, then lowest free entry for a new node
      for (i = 0; i < MAX_NODES; i++)
         if (slot < 0 && node_used[i] && node_key[i] == w.origin_node)
            slot = i;
      for (i = 0; i < MAX_NODES; i++)
         if (slot < 0 && !node_used[i]) begin
            node_used[i] = 1'b1;
            node_key[i]  = w.origin_node;
            node_seq[i]  = '0;
            node_seen[i] = '0;
            slot         = i;
         end
      r      = '0;
      r.kind = KIND_VERDICT;
      r.last = 1'b1;
      if (slot < 0) begin
         r.verdict = VERDICT_FULL;
      end else if (w.time_ms - node_seen[slot] > stale_limit ||
                   w.report_seq > node_seq[slot]) begin
         node_seq[slot]  = w.report_seq;
         node_seen[slot] = w.time_ms;
         // update the node's row or append one
         for (i = 0; i < win_count; i++)
            if (row < 0 && win_rows[i].node == w.origin_node)
               row = i;
         if (row < 0 && win_count < MAX_NODES) begin
            row = win_count;
            win_count++;
         end
         if (row >= 0) begin
            win_rows[row].node        = w.origin_node;
            win_rows[row].time_ms     = w.time_ms;
            win_rows[row].temperature = w.temperature;
            win_rows[row].humidity    = w.humidity;
            win_rows[row].co2         = w.co2_level;
            win_rows[row].voc         = w.voc_level;
         end
         r.verdict = VERDICT_ACCEPTED;
      end else begin
         r.verdict = VERDICT_REJECTED;
      end
      due_words.push_back(r);
   endtask

   // compare one result word with the oldest prediction
   task automatic compare_result(input rsp_type got);
      rsp_type want;
      logic    bad;
      if (due_words.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: result word %0d arrived with none due: %h", $realtime,
                     words_seen, got);
         return;
      end
      want = due_words.pop_front();
      bad  = (got.kind !== want.kind) || (got.verdict !== want.verdict) ||
             (got.rec_node !== want.rec_node) || (got.rec_time !== want.rec_time) ||
             (got.rec_temperature !== want.rec_temperature) ||
             (got.rec_humidity !== want.rec_humidity) ||
             (got.rec_co2 !== want.rec_co2) || (got.rec_voc !== want.rec_voc) ||
             (got.last !== want.last);
      if (bad) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("%0t: result word %0d mismatch", $realtime, words_seen);
            $display("  exp kind=%0d verdict=%0d node=%h time=%h temp=%0d hum=%h co2=%h voc=%h last=%b",
                     want.kind, want.verdict, want.rec_node, want.rec_time,
                     want.rec_temperature, want.rec_humidity, want.rec_co2,
                     want.rec_voc, want.last);
            $display("  got kind=%0d verdict=%0d node=%h time=%h temp=%0d hum=%h co2=%h voc=%h last=%b",
                     got.kind, got.verdict, got.rec_node, got.rec_time,
                     got.rec_temperature, got.rec_humidity, got.rec_co2,
                     got.rec_voc, got.last);
         end
      end
   endtask

   // snoop every handshake at the clock edge
   always @(posedge clock) begin
      if (reset) begin
         stale_limit = STALE_TIMEOUT_RESET;
         win_count   = 0;
         mismatches  = 0;
         words_seen  = 0;
         for (int i = 0; i < MAX_NODES; i++)
            node_used[i] = 1'b0;
         due_words.delete();
      end else begin
         if (csr_wr_en)
            stale_limit = csr_wr_data;
         if (req_valid && !req_stall)
            predict_dedup(req_word);
         if (rsp_valid && !rsp_stall) begin
            compare_result(rsp_word);
            words_seen++;
         end
      end
      pending = due_words.size();
   end

endmodule

// ----- sim/tb_top.sv -----
// tb_top: clock, reset and stimulus for sensor_report_dedup_and_window_table,
// with random idling on both sides and several stale timeout settings
// depends on srdw_pkg, sensor_report_dedup_and_window_table, dedup_window_checker
module tb_top
   import srdw_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODE_SLOTS   = 8;
   localparam int SETTLE_TICKS = 4 * NODE_SLOTS + 10;
   localparam int PHASE_ITEMS  = 30;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_word;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_word;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;
   int          mismatches;
   int          pending;

   // idling is turned off for the tail of the run
   logic        calm = 1'b0;
   int          stall_left = 0;

   logic [7:0]  known_nodes [NODE_SLOTS];
   logic [7:0]  seq_hint    [NODE_SLOTS];
   logic [31:0] now_ms;

   sensor_report_dedup_and_window_table #(.MAX_NODES(NODE_SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   dedup_window_checker #(.MAX_NODES(NODE_SLOTS)) dedup_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .pending     (pending)
   );

   // 4 ns clock
   always #2 clock = ~clock;

   // result side stalls in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(0, 16);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall  <= 1'b0;
      end
   end

   // report word with random readings
   function automatic req_type report_word(input logic [7:0] node, input logic [7:0] seq,
                                           input logic [31:0] stamp);
      req_type w;
      w.action      = ACTION_REPORT;
      w.origin_node = node;
      w.report_seq  = seq;
      w.time_ms     = stamp;
      w.temperature = 16'($urandom);
      w.humidity    = 16'($urandom);
      w.co2_level   = 16'($urandom);
      w.voc_level   = 16'($urandom);
      w.link_ready  = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // flush word, every field but the link flag is noise
   function automatic req_type flush_word(input logic link);
      req_type w;
      w             = report_word(8'($urandom), 8'($urandom), $urandom);
      w.action      = ACTION_FLUSH;
      w.link_ready  = link;
      return w;
   endfunction

   // present one word and hold it until accepted
   task automatic send_word(input req_type w);
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   task automatic maybe_pause();
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
   endtask

   // wait for every due result, then let the block finish a silent flush
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_timeout(input logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // random word: mostly reports from known nodes with nearby sequence bytes
   task automatic send_random_item();
      req_type w;
      int      pick;
      pick = $urandom_range(0, NODE_SLOTS - 1);
      if ($urandom_range(0, 7) == 0) begin
         w = flush_word($urandom_range(0, 3) != 0);
      end else begin
         case ($urandom_range(0, 9))
            0:       now_ms = $urandom;
            1, 2:    now_ms = now_ms + $urandom_range(0, 70000);
            default: now_ms = now_ms + $urandom_range(0, 1500);
         endcase
         if ($urandom_range(0, 9) == 0) begin
            w = report_word(8'($urandom), 8'($urandom), now_ms);
         end else begin
            if ($urandom_range(0, 7) == 0)
               seq_hint[pick] = 8'($urandom);
            else
               seq_hint[pick] = 8'(seq_hint[pick] + $urandom_range(0, 3));
            w = report_word(known_nodes[pick], seq_hint[pick], now_ms);
         end
      end
      maybe_pause();
      send_word(w);
   endtask

   // run limit
   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // stimulus
   initial begin
      req_type     w;
      logic [31:0] limits [5];
      known_nodes = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h02, 8'h80, 8'h7F};
      limits      = '{32'd0, 32'hFFFF_FFFF, 32'd1000, $urandom, STALE_TIMEOUT_RESET};
      for (int i = 0; i < NODE_SLOTS; i++)
         seq_hint[i] = '0;
      now_ms      = 32'd60000;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_word    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part at the reset timeout
      // flush of an empty window gives only the end marker
      send_word(flush_word(1'b1));
      // first report of node 0 with the lowest readings
      w             = report_word(8'h00, 8'd1, 32'd100);
      w.temperature = 16'sh8000;
      w.humidity    = '0;
      w.co2_level   = '0;
      w.voc_level   = '0;
      send_word(w);
      // duplicate sequence
      maybe_pause();
      send_word(report_word(8'h00, 8'd1, 32'd200));
      // elapsed time equal to the timeout is not stale
      send_word(report_word(8'h00, 8'd0, 32'd30100));
      // one past the timeout is stale, any sequence passes
      send_word(report_word(8'h00, 8'd0, 32'd30101));
      // new node with the highest readings and time
      w             = report_word(8'hFF, 8'hFF, 32'hFFFF_FFFF);
      w.temperature = 16'sh7FFF;
      w.humidity    = 16'hFFFF;
      w.co2_level   = 16'hFFFF;
      w.voc_level   = 16'hFFFF;
      w.link_ready  = 1'b0;
      send_word(w);
      // time wrapped past zero, small elapsed time, lower sequence
      send_word(report_word(8'hFF, 8'd0, 32'd5));
      // rejected new node keeps its entry
      send_word(report_word(8'h55, 8'd0, 32'd0));
      send_word(report_word(8'h55, 8'd0, 32'd30001));
      maybe_pause();
      send_word(flush_word(1'b1));
      send_word(report_word(8'hAA, 8'd5, 32'd40000));
      // link down: nothing sent, window still emptied
      send_word(flush_word(1'b0));
      send_word(flush_word(1'b1));
      // fill the remaining entries, then one node too many
      for (int i = 4; i < NODE_SLOTS; i++)
         send_word(report_word(known_nodes[i], 8'd1, 32'd50000));
      send_word(report_word(8'h33, 8'd9, 32'd50000));
      // second report of a node updates its row in place
      send_word(report_word(8'h00, 8'd7, 32'd50000));
      send_word(report_word(8'h00, 8'd8, 32'd50001));
      send_word(flush_word(1'b1));
      wait_idle();

      // random phases, one timeout setting each, quiet tail last
      for (int p = 0; p < 5; p++) begin
         write_timeout(limits[p]);
         if (p == 4)
            calm = 1'b1;
         repeat (PHASE_ITEMS) send_random_item();
         wait_idle();
      end

      if (mismatches == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
